// ===== rtl/core/lmq_pkg.sv =====
// shared constants and codes for the lloyd-max scalar quantizer
`default_nettype none
package lmq_pkg;

    localparam int unsigned NUM_LEVELS_DEF  = 256;
    localparam int unsigned MAX_SAMPLES_DEF = 4096;

    localparam int unsigned ACTION_W   = 3;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned LIDX_W     = 8;
    localparam int unsigned ITER_W     = 4;
    localparam int unsigned SCNT_W     = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [ITER_W-1:0] ITER_RESET = 4'd5;
    localparam logic [SCNT_W-1:0] SCNT_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_ITER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCNT = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_LOAD_SAMPLE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_LEVEL  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN         = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_ASSIGN = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_LEVEL  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/lmq_in_if.sv =====
// input item channel
`default_nettype none
interface lmq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [11:0] address;
    logic signed [15:0] sample_value;

    modport source (output valid, action, address, sample_value, input ready);
    modport sink (input valid, action, address, sample_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lmq_out_if.sv =====
// result item channel
`default_nettype none
interface lmq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [15:0] level_value;
    logic [7:0]  level_index;

    modport source (output valid, status, level_value, level_index, input ready);
    modport sink (input valid, status, level_value, level_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lloyd_max_scalar_quantizer.sv =====
// Lloyd-Max scalar quantizer (1-D k-means). Load, read and unknown actions stream back
// to back while the result port is not stalled; a read returns its data from a registered
// memory port. A run first clears the accumulators, then makes iteration_count passes
// over the n samples, where n is the saturated sample count and SUM_W =
// clog2(MAX_SAMPLES+1) + 16: each sample scans the codebook one level a cycle through
// the level memory port, and each nonempty level goes through a bit-serial divider.
// No item is taken during a run.
`default_nettype none
module lloyd_max_scalar_quantizer #(
    parameter int unsigned NUM_LEVELS  = lmq_pkg::NUM_LEVELS_DEF,
    parameter int unsigned MAX_SAMPLES = lmq_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    lmq_in_if.sink                                 i_item,
    lmq_out_if.source                              o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [lmq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lmq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lmq_pkg::*;

    localparam int unsigned LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int unsigned SW    = $clog2(MAX_SAMPLES);
    localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W = CW + 16;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CLR  = 9'b000000010,
        S_SRD  = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_URD  = 9'b000100000,
        S_UDV  = 9'b001000000,
        S_UWT  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    // memories
    logic signed [15:0]      samp_mem [MAX_SAMPLES];
    logic [LW-1:0]           asg_mem  [MAX_SAMPLES];
    logic signed [15:0]      lvl_mem  [NUM_LEVELS];
    logic signed [SUM_W-1:0] sum_mem  [NUM_LEVELS];
    logic [CW-1:0]           tal_mem  [NUM_LEVELS];

    t_state r_state, n_state;
    logic [ITER_W-1:0] r_iter, r_it, n_it;
    logic [SCNT_W-1:0] r_scnt;
    logic [CW-1:0]     r_n, n_n, r_i, n_i, r_fill, n_fill;
    logic [LW-1:0]     r_k, n_k, r_kc, n_kc, r_best, n_best;
    logic [16:0]       r_bdist, n_bdist;
    logic [NUM_LEVELS-1:0] r_lvalid;

    logic                r_p_valid, n_p_valid, r_p_err, n_p_err;
    logic [ACTION_W-1:0] r_p_act, n_p_act;
    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic signed [15:0]  r_o_lval, n_o_lval;
    logic [LIDX_W-1:0]   r_o_lidx, n_o_lidx;

    logic signed [15:0]      r_samp_rd, r_lvl_rd;
    logic [LW-1:0]           r_asg_rd;
    logic                    r_asg_ok, r_lvl_ok;
    logic signed [SUM_W-1:0] r_sum_rd;
    logic [CW-1:0]           r_tal_rd;

    logic                samp_we, samp_re, asg_we, asg_re, lvl_we, lvl_re, acc_we, acc_re;
    logic [SW-1:0]       samp_wa, samp_ra, asg_wa, asg_ra;
    logic [LW-1:0]       lvl_wa, lvl_ra, acc_wa, acc_ra, asg_wd;
    logic signed [15:0]  lvl_wd;
    logic signed [SUM_W-1:0] sum_wd;
    logic [CW-1:0]       tal_wd;

    logic               accept, out_free, in_rng_s, in_rng_l, is_run, last_k;
    logic signed [16:0] sdist;
    logic [16:0]        adist;
    logic               take;
    logic [LW-1:0]      fin_best;
    logic [CW-1:0]      n_sat;
    logic               div_start, div_done;
    logic signed [15:0] div_quot;

    lmq_div #(.SUM_W(SUM_W), .DEN_W(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum_rd),
        .i_divisor  (r_tal_rd),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign out_free     = !r_o_valid || o_res.ready;
    assign i_item.ready = (r_state == S_IDLE) && (!r_p_valid || out_free);
    assign accept       = i_item.valid && i_item.ready;
    assign is_run       = (i_item.action == ACT_RUN);
    assign in_rng_s     = 32'(i_item.address) < MAX_SAMPLES;
    assign in_rng_l     = 32'(i_item.address) < NUM_LEVELS;
    assign last_k       = (r_k == LW'(NUM_LEVELS - 1));
    assign n_sat        = (32'(r_scnt) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : CW'(r_scnt);

    // codebook scan: distance of the level that arrived this cycle
    always_comb begin
        sdist    = 17'(r_lvl_ok ? r_lvl_rd : 16'sd0) - 17'(r_samp_rd);
        adist    = sdist[16] ? 17'(-sdist) : 17'(sdist);
        take     = (r_kc == '0) || (adist < r_bdist);
        fin_best = take ? r_kc : r_best;
    end

    always_comb begin
        n_state   = r_state;
        n_it      = r_it;
        n_n       = r_n;
        n_i       = r_i;
        n_k       = r_k;
        n_kc      = r_kc;
        n_best    = r_best;
        n_bdist   = r_bdist;
        n_fill    = r_fill;
        n_p_valid = r_p_valid;
        n_p_act   = r_p_act;
        n_p_err   = r_p_err;
        n_o_valid = r_o_valid;
        n_o_status = r_o_status;
        n_o_lval  = r_o_lval;
        n_o_lidx  = r_o_lidx;

        samp_we = 1'b0; samp_wa = SW'(i_item.address);
        samp_re = 1'b0; samp_ra = r_i[SW-1:0];
        asg_we  = 1'b0; asg_wa  = r_i[SW-1:0]; asg_wd = fin_best;
        asg_re  = 1'b0; asg_ra  = SW'(i_item.address);
        lvl_we  = 1'b0; lvl_wa  = LW'(i_item.address); lvl_wd = i_item.sample_value;
        lvl_re  = 1'b0; lvl_ra  = r_k;
        acc_we  = 1'b0; acc_wa  = r_k; sum_wd = '0; tal_wd = '0;
        acc_re  = 1'b0; acc_ra  = r_k;
        div_start = 1'b0;

        if (o_res.ready) begin
            n_o_valid = 1'b0;
        end
        if (r_p_valid && out_free) begin
            n_p_valid  = 1'b0;
            n_o_valid  = 1'b1;
            n_o_status = r_p_err ? ST_RANGE : ST_OK;
            n_o_lval   = (r_p_act == ACT_READ_LEVEL && !r_p_err && r_lvl_ok) ? r_lvl_rd : '0;
            n_o_lidx   = (r_p_act == ACT_READ_ASSIGN && !r_p_err && r_asg_ok)
                         ? LIDX_W'(r_asg_rd) : '0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_run) begin
                        n_n  = n_sat;
                        n_it = '0;
                        n_k  = '0;
                        if (r_iter == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_CLR;
                            if (n_sat > r_fill) n_fill = n_sat;
                        end
                    end else begin
                        n_p_valid = 1'b1;
                        n_p_act   = i_item.action;
                        n_p_err   = 1'b0;
                        case (i_item.action)
                            ACT_LOAD_SAMPLE: begin
                                n_p_err = !in_rng_s;
                                samp_we = in_rng_s;
                            end
                            ACT_LOAD_LEVEL: begin
                                n_p_err = !in_rng_l;
                                lvl_we  = in_rng_l;
                            end
                            ACT_READ_ASSIGN: begin
                                n_p_err = !in_rng_s;
                                asg_re  = 1'b1;
                            end
                            ACT_READ_LEVEL: begin
                                n_p_err = !in_rng_l;
                                lvl_re  = 1'b1;
                                lvl_ra  = LW'(i_item.address);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_CLR: begin
                acc_we = 1'b1;
                if (last_k) begin
                    n_k = '0;
                    n_i = '0;
                    n_state = (r_n == '0) ? S_URD : S_SRD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SRD: begin
                samp_re = 1'b1;
                lvl_re  = 1'b1;
                lvl_ra  = '0;
                n_k     = LW'(1);
                n_kc    = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_bdist = take ? adist : r_bdist;
                n_best  = fin_best;
                lvl_re  = 1'b1;
                n_k     = r_k + 1'b1;
                n_kc    = r_k;
                if (r_kc == LW'(NUM_LEVELS - 1)) begin
                    asg_we  = 1'b1;
                    acc_re  = 1'b1;
                    acc_ra  = fin_best;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                acc_we = 1'b1;
                acc_wa = r_best;
                sum_wd = r_sum_rd + SUM_W'(r_samp_rd);
                tal_wd = r_tal_rd + 1'b1;
                if (r_i == r_n - 1'b1) begin
                    n_k = '0;
                    n_state = S_URD;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_URD: begin
                acc_re  = 1'b1;
                n_state = S_UDV;
            end
            S_UDV, S_UWT: begin
                if (r_state == S_UDV && r_tal_rd != '0) begin
                    div_start = 1'b1;
                    n_state   = S_UWT;
                end else if (r_state == S_UDV || div_done) begin
                    // empty levels go to zero; accumulators are cleared for the next pass
                    lvl_we = 1'b1;
                    lvl_wa = r_k;
                    lvl_wd = (r_state == S_UDV) ? 16'sd0 : div_quot;
                    acc_we = 1'b1;
                    if (last_k) begin
                        n_k = '0;
                        n_i = '0;
                        if (r_it == r_iter - 1'b1) begin
                            n_state = S_DONE;
                        end else begin
                            n_it = r_it + 1'b1;
                            n_state = (r_n == '0) ? S_URD : S_SRD;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_URD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_DONE;
                    n_o_lval   = '0;
                    n_o_lidx   = '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iter    <= ITER_RESET;
            r_scnt    <= SCNT_RESET;
            r_fill    <= '0;
            r_lvalid  <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_it      <= '0;
            r_n       <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_kc      <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
            r_it      <= n_it;
            r_n       <= n_n;
            r_i       <= n_i;
            r_k       <= n_k;
            r_kc      <= n_kc;
            if (lvl_we) r_lvalid[lvl_wa] <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ITER: r_iter <= i_cfg_data[ITER_W-1:0];
                    CFG_SCNT: r_scnt <= i_cfg_data[SCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_bdist    <= n_bdist;
        r_p_act    <= n_p_act;
        r_p_err    <= n_p_err;
        r_o_status <= n_o_status;
        r_o_lval   <= n_o_lval;
        r_o_lidx   <= n_o_lidx;
    end

    always_ff @(posedge i_clk) begin
        if (samp_we) samp_mem[samp_wa] <= i_item.sample_value;
        if (samp_re) r_samp_rd <= samp_mem[samp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (asg_we) asg_mem[asg_wa] <= asg_wd;
        if (asg_re) begin
            r_asg_rd <= asg_mem[asg_ra];
            r_asg_ok <= 32'(i_item.address) < 32'(r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
        if (lvl_re) begin
            r_lvl_rd <= lvl_mem[lvl_ra];
            r_lvl_ok <= r_lvalid[lvl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            sum_mem[acc_wa] <= sum_wd;
            tal_mem[acc_wa] <= tal_wd;
        end
        if (acc_re) begin
            r_sum_rd <= sum_mem[acc_ra];
            r_tal_rd <= tal_mem[acc_ra];
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.status      = r_o_status;
    assign o_res.level_value = r_o_lval;
    assign o_res.level_index = r_o_lidx;
endmodule
`default_nettype wire

// ===== rtl/core/lmq_div.sv =====
// serial signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module lmq_div #(
    parameter int unsigned SUM_W = 29,
    parameter int unsigned DEN_W = 13
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0]        i_divisor,
    output logic                         o_done,
    output logic signed [15:0]           o_quot
);
    localparam int unsigned CNT_W = $clog2(SUM_W);

    logic             r_busy, r_done, r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W:0]   diff;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] qs;

    always_comb begin
        mag   = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        trial = {r_rem, r_q[SUM_W-1]};
        qbit  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
        qs    = r_neg ? (~r_q + 1'b1) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], qbit};
            r_rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = qs[15:0];
endmodule
`default_nettype wire

// ===== rtl/core/lmq_chk.sv =====
// port-level checks for the lloyd-max scalar quantizer, bound to the top level
`default_nettype none
module lmq_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [15:0] i_level_value,
    input wire logic [7:0]  i_level_index
);
    import lmq_pkg::*;

    // a pending result stays until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_DONE || i_status == ST_RANGE))
        else $error("bad status code");

    // only an accepted action carries data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_level_value == '0 && i_level_index == '0)
        else $error("data on a run or range result");
endmodule

bind lloyd_max_scalar_quantizer lmq_chk u_lmq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_level_value (o_res.level_value),
    .i_level_index (o_res.level_index)
);
`default_nettype wire
